// ===== hdl/assert_macros.svh =====
// Assertion helper macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property that holds even during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/sdh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdh_pkg
// Types and constants of the SPI-mode SD host engine.
// ----------------------------------------------------------------------------
package sdh_pkg;

    // Block size and write buffer address width.
    localparam int BLOCK_BYTES = 512;
    localparam int BUF_AW      = $clog2(BLOCK_BYTES);

    // Host request codes.
    localparam logic [2:0] CMD_XCHG  = 3'd0;
    localparam logic [2:0] CMD_INIT  = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_R1   = 2'd0;
    localparam logic [1:0] CFG_V2   = 2'd1;
    localparam logic [1:0] CFG_V1   = 2'd2;
    localparam logic [1:0] CFG_BUSY = 2'd3;

    // Completion status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_IDLE = 2'd1;
    localparam logic [1:0] ST_RD_FAIL = 2'd2;
    localparam logic [1:0] ST_WR_FAIL = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE, PH_PRE, PH_FRAME, PH_R1, PH_REL, PH_OCR,
        PH_RD_GAP, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
        PH_WR_TOKEN, PH_WR_DATA, PH_WR_REL, PH_WR_RESP, PH_WR_BUSY
    } t_phase;

    typedef enum logic [3:0] {
        SG_GO_IDLE, SG_GO_IDLE_REL, SG_IF_COND, SG_IF_COND_OCR, SG_V2_WAIT,
        SG_READ_OCR, SG_READ_OCR_DATA, SG_V1_PROBE, SG_V1_WAIT, SG_BLOCKLEN,
        SG_READ, SG_WRITE, SG_WRITE_REL
    } t_stage;

    // Buffer access request from the controller to the buffer memory.
    typedef struct packed {
        logic              wr_en;
        logic [BUF_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [BUF_AW-1:0] rd_addr;
    } t_buf_req;

endpackage

// ===== hdl/sd_card_spi_host_engine.sv =====
// ----------------------------------------------------------------------------
// sd_card_spi_host_engine
// SPI-mode SD/MMC host: command framing, init tree, block read and write.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle and its result item appears in the
// output register on the following edge. A new item is accepted in the same
// cycle as the waiting result leaves; while that result is stalled the input
// is stalled too. The write buffer sits in a synchronous memory with a
// registered read; each data exchange reads the byte it sends at its own
// edge and the byte is shown straight from the memory port. Loads and data
// reads are separate items, so they never meet in one cycle. No clearing pass.
module sd_card_spi_host_engine
    import sdh_pkg::*;
#(
    parameter int WAKE_BYTES  = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_block_address,
    input  logic [8:0]  i_load_index,
    input  logic [7:0]  i_load_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_chip_select,
    output logic        o_slow_clock,
    output logic        o_read_valid,
    output logic [7:0]  o_read_data,
    output logic        o_read_last,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [2:0]  o_card_type
);
    localparam int AW = BUF_AW;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] BLK = CW'(BLOCK_BYTES);

    // Configuration registers.
    logic [7:0]  r_r1_lim;
    logic [15:0] r_v2_ret, r_v1_ret, r_busy_lim;

    // Engine state.
    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0] r_retry, n_retry;
    logic [47:0] r_frame, n_frame;
    logic        r_app, n_app;
    logic [5:0]  r_app_idx, n_app_idx;
    logic [31:0] r_app_arg, n_app_arg;
    logic [31:0] r_resp, n_resp;
    logic [2:0]  r_type, n_type;
    logic [7:0]  r_tx, n_tx;
    logic        r_cs, n_cs, r_slow, n_slow;
    logic        r_tx_from_buf, n_tx_from_buf;

    // Output register.
    logic        r_ovalid;
    logic        r_rv, n_rv, r_rl, n_rl, r_done, n_done;
    logic [7:0]  r_rd, n_rd;
    logic [1:0]  r_st, n_st;
    logic        r_otxv;
    logic [7:0]  r_otx;

    logic        acc;
    logic [7:0]  buf_q;
    t_buf_req    breq;

    assign o_stall     = r_ovalid & i_stall;
    assign o_cfg_ready = 1'b1;
    assign acc         = i_valid & ~o_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_lim   <= 8'd10;
            r_v2_ret   <= 16'd12000;
            r_v1_ret   <= 16'd25000;
            r_busy_lim <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_R1:   r_r1_lim   <= i_cfg_data[7:0];
                CFG_V2:   r_v2_ret   <= i_cfg_data;
                CFG_V1:   r_v1_ret   <= i_cfg_data;
                CFG_BUSY: r_busy_lim <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Buffer memory: loads write, the data phase reads the byte it sends.
    sdh_wbuf #(.DEPTH(BLOCK_BYTES), .AW(AW)) u_wbuf (
        .i_clk (i_clk),
        .i_we  (breq.wr_en),
        .i_wa  (breq.wr_addr[AW-1:0]),
        .i_wd  (breq.wr_data),
        .i_re  (breq.rd_en),
        .i_ra  (breq.rd_addr[AW-1:0]),
        .o_rd  (buf_q)
    );

    logic [7:0] cur_tx;
    assign cur_tx = r_tx_from_buf ? buf_q : r_tx;

    // Next-state logic: one decision per item.
    always_comb begin
        logic [7:0] crc;
        logic [5:0] cidx;
        logic [31:0] carg;
        logic       do_cmd, do_app, do_fin;
        logic [1:0] fst;
        logic [7:0] r1;
        logic [15:0] rdec;
        logic [31:0] rw;
        n_phase = r_phase; n_stage = r_stage; n_cnt = r_cnt; n_retry = r_retry;
        n_frame = r_frame; n_app = r_app; n_app_idx = r_app_idx;
        n_app_arg = r_app_arg; n_resp = r_resp; n_type = r_type;
        n_tx = cur_tx; n_cs = r_cs; n_slow = r_slow; n_tx_from_buf = 1'b0;
        n_rv = 1'b0; n_rd = 8'd0; n_rl = 1'b0; n_done = 1'b0; n_st = ST_OK;
        breq = '0;
        do_cmd = 1'b0; do_app = 1'b0; do_fin = 1'b0; fst = ST_OK;
        cidx = 6'd0; carg = 32'd0; crc = 8'h01;
        r1 = i_rx_byte;
        rdec = r_retry - 16'd1;
        rw = {r_resp[23:0], i_rx_byte};

        if (acc) begin
            if (i_command == CMD_XCHG) begin
                case (r_phase)
                    PH_IDLE: ;
                    PH_WAKE: begin
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= CW'(WAKE_BYTES)) begin
                            n_slow = 1'b0; n_cs = 1'b1;
                            n_stage = SG_GO_IDLE; do_cmd = 1'b1; cidx = 6'd0;
                        end
                    end
                    PH_PRE: begin
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= CW'(2)) begin
                            n_cnt = '0; n_phase = PH_FRAME; n_tx = r_frame[47:40];
                        end
                    end
                    PH_FRAME: begin
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= CW'(6)) begin
                            n_cnt = CW'(r_r1_lim); n_phase = PH_R1; n_tx = 8'hFF;
                        end else begin
                            n_tx = r_frame[39:32];
                        end
                        n_frame = {r_frame[39:0], 8'h00};
                    end
                    PH_R1: begin
                        n_cnt = CW'(8'(r_cnt[7:0] - 8'd1));
                        if (!r1[7] || n_cnt == '0) begin
                            if (r_app && r1 <= 8'd1) begin
                                n_app = 1'b0; do_cmd = 1'b1;
                                cidx = r_app_idx; carg = r_app_arg;
                            end else begin
                                n_app = 1'b0;
                                case (r_stage)
                                    SG_GO_IDLE: begin
                                        if (r1 == 8'd1) begin
                                            n_stage = SG_GO_IDLE_REL;
                                            n_phase = PH_REL; n_tx = 8'hFF;
                                        end else begin
                                            do_fin = 1'b1; fst = ST_NO_IDLE;
                                        end
                                    end
                                    SG_IF_COND: begin
                                        if (r1 == 8'd1) begin
                                            n_stage = SG_IF_COND_OCR; n_resp = '0;
                                            n_cnt = '0; n_phase = PH_OCR; n_tx = 8'hFF;
                                        end else begin
                                            n_stage = SG_V1_PROBE; do_app = 1'b1;
                                            cidx = 6'd41;
                                        end
                                    end
                                    SG_V2_WAIT: begin
                                        if (r1 == 8'd0) begin
                                            n_stage = SG_READ_OCR; do_cmd = 1'b1;
                                            cidx = 6'd58;
                                        end else begin
                                            n_retry = rdec;
                                            if (rdec == '0) do_fin = 1'b1;
                                            else begin
                                                do_app = 1'b1; cidx = 6'd41;
                                                carg = 32'h4000_0000;
                                            end
                                        end
                                    end
                                    SG_READ_OCR: begin
                                        if (r1 == 8'd0) begin
                                            n_stage = SG_READ_OCR_DATA; n_resp = '0;
                                            n_cnt = '0; n_phase = PH_OCR; n_tx = 8'hFF;
                                        end else do_fin = 1'b1;
                                    end
                                    SG_V1_PROBE: begin
                                        n_type = (r1 <= 8'd1) ? 3'd2 : 3'd1;
                                        n_retry = r_v1_ret;
                                        if (r_v1_ret == '0) begin
                                            n_type = 3'd0; do_fin = 1'b1;
                                        end else begin
                                            n_stage = SG_V1_WAIT;
                                            if (n_type == 3'd2) begin
                                                do_app = 1'b1; cidx = 6'd41;
                                            end else begin
                                                do_cmd = 1'b1; cidx = 6'd1;
                                            end
                                        end
                                    end
                                    SG_V1_WAIT: begin
                                        if (r1 == 8'd0) begin
                                            n_stage = SG_BLOCKLEN; do_cmd = 1'b1;
                                            cidx = 6'd16; carg = 32'(BLOCK_BYTES);
                                        end else begin
                                            n_retry = rdec;
                                            if (rdec == '0) begin
                                                n_type = 3'd0; do_fin = 1'b1;
                                            end else if (r_type == 3'd2) begin
                                                do_app = 1'b1; cidx = 6'd41;
                                            end else begin
                                                do_cmd = 1'b1; cidx = 6'd1;
                                            end
                                        end
                                    end
                                    SG_BLOCKLEN: begin
                                        if (r1 != 8'd0) n_type = 3'd0;
                                        do_fin = 1'b1;
                                    end
                                    SG_READ: begin
                                        if (r1 != 8'd0) begin
                                            do_fin = 1'b1; fst = ST_RD_FAIL;
                                        end else begin
                                            n_phase = PH_RD_GAP; n_tx = 8'hFF;
                                        end
                                    end
                                    SG_WRITE: begin
                                        if (r1 != 8'd0) begin
                                            do_fin = 1'b1; fst = ST_WR_FAIL;
                                        end else begin
                                            n_stage = SG_WRITE_REL;
                                            n_phase = PH_REL; n_tx = 8'hFF;
                                        end
                                    end
                                    default: do_fin = 1'b1;
                                endcase
                            end
                        end
                    end
                    PH_REL: begin
                        if (r_stage == SG_GO_IDLE_REL) begin
                            n_stage = SG_IF_COND; do_cmd = 1'b1;
                            cidx = 6'd8; carg = 32'h0000_01AA;
                        end else begin
                            n_phase = PH_WR_TOKEN; n_tx = 8'hFE;
                        end
                    end
                    PH_OCR: begin
                        n_resp = rw;
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= CW'(4)) begin
                            if (r_stage == SG_IF_COND_OCR) begin
                                n_retry = r_v2_ret;
                                if (rw[15:0] == 16'h01AA && r_v2_ret != '0) begin
                                    n_stage = SG_V2_WAIT; do_app = 1'b1;
                                    cidx = 6'd41; carg = 32'h4000_0000;
                                end else do_fin = 1'b1;
                            end else begin
                                n_type = rw[30] ? 3'd4 : 3'd3;
                                do_fin = 1'b1;
                            end
                        end
                    end
                    PH_RD_GAP: begin
                        n_retry = r_busy_lim; n_phase = PH_RD_TOKEN; n_tx = 8'hFF;
                    end
                    PH_RD_TOKEN: begin
                        if (i_rx_byte == 8'hFE) begin
                            n_cnt = '0; n_phase = PH_RD_DATA; n_tx = 8'hFF;
                        end else begin
                            n_retry = rdec;
                            if (rdec == '0) begin
                                do_fin = 1'b1; fst = ST_RD_FAIL;
                            end
                        end
                    end
                    PH_RD_DATA: begin
                        n_rv = 1'b1; n_rd = i_rx_byte;
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= BLK) begin
                            n_rl = 1'b1; n_cnt = '0; n_phase = PH_RD_CRC; n_tx = 8'hFF;
                        end
                    end
                    PH_RD_CRC: begin
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= CW'(2)) do_fin = 1'b1;
                    end
                    PH_WR_TOKEN: begin
                        // The first data byte is read at this edge.
                        n_cnt = '0; n_phase = PH_WR_DATA; n_tx_from_buf = 1'b1;
                        breq.rd_en = 1'b1; breq.rd_addr = '0;
                    end
                    PH_WR_DATA: begin
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= BLK) begin
                            n_cnt = '0; n_phase = PH_WR_REL; n_tx = 8'hFF;
                        end else begin
                            n_tx_from_buf = 1'b1;
                            breq.rd_en = 1'b1;
                            breq.rd_addr = n_cnt[AW-1:0];
                        end
                    end
                    PH_WR_REL: begin
                        n_cnt = r_cnt + 1'b1;
                        if (n_cnt >= CW'(2)) n_phase = PH_WR_RESP;
                    end
                    PH_WR_RESP: begin
                        if ((i_rx_byte & 8'h05) != 8'h05) begin
                            do_fin = 1'b1; fst = ST_WR_FAIL;
                        end else begin
                            n_retry = r_busy_lim; n_phase = PH_WR_BUSY;
                        end
                    end
                    PH_WR_BUSY: begin
                        if (i_rx_byte == 8'hFF) do_fin = 1'b1;
                        else begin
                            n_retry = rdec;
                            if (rdec == '0) begin
                                do_fin = 1'b1; fst = ST_WR_FAIL;
                            end
                        end
                    end
                    default: ;
                endcase
            end else if (i_command == CMD_LOAD) begin
                n_tx_from_buf = r_tx_from_buf;
                if (32'(i_load_index) < 32'(BLOCK_BYTES)) begin
                    breq.wr_en = 1'b1; breq.wr_addr = i_load_index;
                    breq.wr_data = i_load_byte;
                end
                // Keep the fetched byte while the data phase waits.
                if (r_tx_from_buf) begin
                    n_tx = r_tx;
                end
            end else if (r_phase == PH_IDLE) begin
                case (i_command)
                    CMD_INIT: begin
                        n_type = 3'd0; n_slow = 1'b1; n_cs = 1'b0;
                        n_cnt = '0; n_phase = PH_WAKE; n_tx = 8'hFF;
                    end
                    CMD_READ: begin
                        n_cs = 1'b1; n_stage = SG_READ; do_cmd = 1'b1;
                        cidx = 6'd17; carg = i_block_address;
                    end
                    CMD_WRITE: begin
                        n_cs = 1'b1; n_stage = SG_WRITE; do_cmd = 1'b1;
                        cidx = 6'd24; carg = i_block_address;
                    end
                    default: ;
                endcase
            end else begin
                n_tx_from_buf = r_tx_from_buf;
            end

            // Command framing, with the CMD55 prefix for app commands.
            if (do_app) begin
                n_app = 1'b1; n_app_idx = cidx; n_app_arg = carg;
                cidx = 6'd55; carg = 32'd0; do_cmd = 1'b1;
            end else if (do_cmd && !(r_phase == PH_R1 && r_app)) begin
                n_app = 1'b0;
            end
            if (do_cmd) begin
                if (cidx == 6'd0) crc = 8'h95;
                else if (cidx == 6'd8) crc = 8'h87;
                n_frame = {2'b01, cidx, carg, crc};
                n_cnt = '0; n_phase = PH_PRE; n_tx = 8'hFF;
            end
            if (do_fin) begin
                n_phase = PH_IDLE; n_tx = 8'h00; n_done = 1'b1; n_st = fst;
            end
        end else begin
            n_tx_from_buf = r_tx_from_buf;
            n_tx = r_tx;
        end
    end

    // State and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_stage <= SG_GO_IDLE; r_cnt <= '0; r_retry <= '0;
            r_frame <= '0; r_app <= 1'b0; r_app_idx <= '0; r_app_arg <= '0;
            r_resp <= '0; r_type <= '0; r_tx <= '0; r_cs <= 1'b0; r_slow <= 1'b0;
            r_tx_from_buf <= 1'b0; r_ovalid <= 1'b0;
            r_rv <= 1'b0; r_rl <= 1'b0; r_done <= 1'b0; r_st <= '0; r_rd <= '0;
            r_otxv <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase; r_stage <= n_stage; r_cnt <= n_cnt;
                r_retry <= n_retry; r_frame <= n_frame; r_app <= n_app;
                r_app_idx <= n_app_idx; r_app_arg <= n_app_arg; r_resp <= n_resp;
                r_type <= n_type; r_cs <= n_cs; r_slow <= n_slow;
                r_tx_from_buf <= n_tx_from_buf;
                r_tx <= n_tx_from_buf ? r_tx : n_tx;
                r_rv <= n_rv; r_rd <= n_rd; r_rl <= n_rl; r_done <= n_done;
                r_st <= n_st;
                r_otxv <= (n_phase != PH_IDLE);
            end else if (r_tx_from_buf) begin
                r_tx <= cur_tx;
                r_tx_from_buf <= 1'b0;
            end
            if (acc) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    // Transmit byte shown: buffer data is taken straight from the memory port.
    logic r_show_buf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_buf <= 1'b0;
            r_otx      <= '0;
        end else begin
            if (acc) r_show_buf <= n_tx_from_buf;
            else r_show_buf <= 1'b0;
            if (acc && !n_tx_from_buf) r_otx <= (n_phase != PH_IDLE) ? n_tx : 8'h00;
            else if (!acc && r_show_buf) r_otx <= cur_tx;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_tx_valid    = r_otxv;
    assign o_tx_byte     = r_show_buf ? cur_tx : r_otx;
    assign o_chip_select = r_cs;
    assign o_slow_clock  = r_slow;
    assign o_read_valid  = r_rv;
    assign o_read_data   = r_rd;
    assign o_read_last   = r_rl;
    assign o_done_res    = r_done;
    assign o_status      = r_st;
    assign o_card_type   = r_type;
endmodule

// ===== hdl/sdh_wbuf.sv =====
// ----------------------------------------------------------------------------
// sdh_wbuf
// Write block buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdh_wbuf
    import sdh_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_wa,
    input  logic [7:0]     i_wd,
    input  logic           i_re,
    input  logic [AW-1:0]  i_ra,
    output logic [7:0]     o_rd
);
    logic [7:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= mem[i_ra];
        end
    end
endmodule

// ===== hdl/sdh_checker.sv =====
// ----------------------------------------------------------------------------
// sdh_checker
// Port-level checks of the SPI-mode SD host engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sdh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_done_res,
    input logic [1:0] o_status,
    input logic       o_read_valid,
    input logic [7:0] o_read_data,
    input logic       o_read_last
);
    // A stalled result holds its payload.
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> $stable({o_done_res, o_status, o_tx_byte, o_read_data}), "result changed under stall")
    // Status is only non-zero on completion.
    `ASSERT_IMPL(a_status, i_clk, i_rst_n, !o_done_res |-> o_status == 2'd0, "status without done")
    // Idle transmit byte is zero.
    `ASSERT_IMPL(a_txz, i_clk, i_rst_n, !o_tx_valid |-> o_tx_byte == 8'd0, "tx byte while idle")
    // Last flag only with read data.
    `ASSERT_IMPL(a_last, i_clk, i_rst_n, o_read_last |-> o_read_valid, "last without data")
    // Done leaves no exchange pending.
    `ASSERT_IMPL(a_done, i_clk, i_rst_n, o_done_res |-> !o_tx_valid, "done while busy")
endmodule

bind sd_card_spi_host_engine sdh_checker u_sdh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_tx_valid(o_tx_valid), .o_tx_byte(o_tx_byte), .o_done_res(o_done_res),
    .o_status(o_status), .o_read_valid(o_read_valid),
    .o_read_data(o_read_data), .o_read_last(o_read_last)
);

// ===== test/tb_sd_card_spi_host_engine.sv =====
// ----------------------------------------------------------------------------
// tb_sd_card_spi_host_engine
// Self-checking bench for the SPI-mode SD host engine. A behavioural copy of
// the engine predicts each result no directed row fixes. A simple card model
// answers random exchanges from the predicted state, so initialisation, reads
// and writes run to their ends. It also sends noise, ignored starts, loads.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_host_engine;
    import sdh_pkg::*;

    localparam int BLOCK      = 512;
    localparam int WAKE       = 10;
    localparam int PHASE_ITEMS = 270;
    localparam int WD_LIMIT   = 4000;

    localparam logic [2:0] CT_NONE = 3'd0;
    localparam logic [2:0] CT_SD1  = 3'd2;
    localparam logic [2:0] CT_SD2  = 3'd3;
    localparam logic [2:0] CT_SD2B = 3'd4;
    localparam logic [2:0] CT_MMC  = 3'd1;

    typedef struct packed {
        logic       txv;
        logic [7:0] tx;
        logic       cs;
        logic       slow;
        logic       rv;
        logic [7:0] rd;
        logic       rl;
        logic       done;
        logic [1:0] st;
        logic [2:0] ct;
    } t_res;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  rx;
        logic [31:0] addr;
        logic [8:0]  li;
        logic [7:0]  lb;
        bit          chk;
        t_res        want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [31:0] i_block_address = '0;
    logic [8:0]  i_load_index = '0;
    logic [7:0]  i_load_byte = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_chip_select;
    logic        o_slow_clock;
    logic        o_read_valid;
    logic [7:0]  o_read_data;
    logic        o_read_last;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [2:0]  o_card_type;

    sd_card_spi_host_engine i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Engine state mirrored by the predictor.
    logic [7:0]  c_r1 = 8'd10;
    logic [15:0] c_v2 = 16'd12000;
    logic [15:0] c_v1 = 16'd25000;
    logic [15:0] c_busy = 16'hFFFF;
    t_phase      m_ph = PH_IDLE;
    t_stage      m_sg = SG_GO_IDLE;
    logic [9:0]  m_bc = '0;
    logic [15:0] m_retry = '0;
    logic [47:0] m_frame = '0;
    logic        m_app = 1'b0;
    logic [5:0]  m_app_idx = '0;
    logic [31:0] m_app_arg = '0;
    logic [31:0] m_resp = '0;
    logic [2:0]  m_type = CT_NONE;
    logic [7:0]  m_tx = '0;
    logic        m_cs = 1'b0;
    logic        m_slow = 1'b0;
    t_res        m_out;
    logic [7:0]  wbuf [BLOCK];

    t_res        engine_outputs_q [$];
    int          fail_cnt = 0;
    int          wd_cnt = 0;
    bit          calm_rx = 1'b0;
    int          stall_left = 0;

    function automatic void eng_go(t_phase p, logic [7:0] tx);
        m_ph = p;
        m_tx = tx;
    endfunction

    function automatic void eng_finish(logic [1:0] st);
        m_ph = PH_IDLE;
        m_tx = 8'h00;
        m_out.done = 1'b1;
        m_out.st = st;
    endfunction

    // Command frame: index with start bits, argument, fixed CRC byte.
    function automatic void eng_frame(logic [5:0] idx, logic [31:0] arg);
        logic [7:0] crc;
        crc = 8'h01;
        if (idx == 6'd0) crc = 8'h95;
        if (idx == 6'd8) crc = 8'h87;
        m_frame = {2'b01, idx, arg, crc};
        m_bc = '0;
        eng_go(PH_PRE, 8'hFF);
    endfunction

    // An application command goes out behind a CMD55 prefix.
    function automatic void eng_send(t_stage sg, logic [5:0] idx, logic [31:0] arg, bit app);
        m_sg = sg;
        if (app) begin
            m_app_idx = idx;
            m_app_arg = arg;
            m_app = 1'b1;
            eng_frame(6'd55, 32'd0);
        end else begin
            m_app = 1'b0;
            eng_frame(idx, arg);
        end
    endfunction

    function automatic void eng_ocr(t_stage sg);
        m_sg = sg;
        m_resp = '0;
        m_bc = '0;
        eng_go(PH_OCR, 8'hFF);
    endfunction

    function automatic void eng_v1_try();
        eng_send(SG_V1_WAIT, (m_type == CT_SD1) ? 6'd41 : 6'd1, 32'd0, m_type == CT_SD1);
    endfunction

    // Decision taken once the R1 of a command is in.
    function automatic void eng_cmd_done(logic [7:0] r1);
        case (m_sg)
            SG_GO_IDLE: begin
                if (r1 == 8'h01) begin
                    m_sg = SG_GO_IDLE_REL;
                    eng_go(PH_REL, 8'hFF);
                end else eng_finish(ST_NO_IDLE);
            end
            SG_IF_COND: begin
                if (r1 == 8'h01) eng_ocr(SG_IF_COND_OCR);
                else eng_send(SG_V1_PROBE, 6'd41, 32'd0, 1'b1);
            end
            SG_V2_WAIT: begin
                if (r1 == 8'h00) eng_send(SG_READ_OCR, 6'd58, 32'd0, 1'b0);
                else begin
                    m_retry = m_retry - 16'd1;
                    if (m_retry == 16'd0) eng_finish(ST_OK);
                    else eng_send(SG_V2_WAIT, 6'd41, 32'h4000_0000, 1'b1);
                end
            end
            SG_READ_OCR: begin
                if (r1 == 8'h00) eng_ocr(SG_READ_OCR_DATA);
                else eng_finish(ST_OK);
            end
            SG_V1_PROBE: begin
                m_type = (r1 <= 8'h01) ? CT_SD1 : CT_MMC;
                m_retry = c_v1;
                if (m_retry == 16'd0) begin
                    m_type = CT_NONE;
                    eng_finish(ST_OK);
                end else eng_v1_try();
            end
            SG_V1_WAIT: begin
                if (r1 == 8'h00) eng_send(SG_BLOCKLEN, 6'd16, BLOCK, 1'b0);
                else begin
                    m_retry = m_retry - 16'd1;
                    if (m_retry == 16'd0) begin
                        m_type = CT_NONE;
                        eng_finish(ST_OK);
                    end else eng_v1_try();
                end
            end
            SG_BLOCKLEN: begin
                if (r1 != 8'h00) m_type = CT_NONE;
                eng_finish(ST_OK);
            end
            SG_READ: begin
                if (r1 != 8'h00) eng_finish(ST_RD_FAIL);
                else eng_go(PH_RD_GAP, 8'hFF);
            end
            SG_WRITE: begin
                if (r1 != 8'h00) eng_finish(ST_WR_FAIL);
                else begin
                    m_sg = SG_WRITE_REL;
                    eng_go(PH_REL, 8'hFF);
                end
            end
            default: eng_finish(ST_OK);
        endcase
    endfunction

    // One finished byte exchange.
    function automatic void eng_exchange(logic [7:0] rx);
        case (m_ph)
            PH_WAKE: begin
                m_bc++;
                if (m_bc >= WAKE) begin
                    m_slow = 1'b0;
                    m_cs = 1'b1;
                    eng_send(SG_GO_IDLE, 6'd0, 32'd0, 1'b0);
                end
            end
            PH_PRE: begin
                m_bc++;
                if (m_bc >= 2) begin
                    m_bc = '0;
                    eng_go(PH_FRAME, m_frame[47:40]);
                end
            end
            PH_FRAME: begin
                m_bc++;
                if (m_bc >= 6) begin
                    m_bc = {2'b00, c_r1};
                    eng_go(PH_R1, 8'hFF);
                end else eng_go(PH_FRAME, 8'(m_frame >> (40 - 8 * int'(m_bc))));
            end
            PH_R1: begin
                m_bc = {2'b00, m_bc[7:0] - 8'd1};
                if (!rx[7] || m_bc == '0) begin
                    if (m_app) begin
                        m_app = 1'b0;
                        if (rx > 8'h01) eng_cmd_done(rx);
                        else eng_frame(m_app_idx, m_app_arg);
                    end else eng_cmd_done(rx);
                end
            end
            PH_REL: begin
                if (m_sg == SG_GO_IDLE_REL) eng_send(SG_IF_COND, 6'd8, 32'h1AA, 1'b0);
                else eng_go(PH_WR_TOKEN, 8'hFE);
            end
            PH_OCR: begin
                m_resp = {m_resp[23:0], rx};
                m_bc++;
                if (m_bc >= 4) begin
                    if (m_sg == SG_IF_COND_OCR) begin
                        m_retry = c_v2;
                        if (m_resp[15:0] == 16'h01AA && m_retry != 16'd0)
                            eng_send(SG_V2_WAIT, 6'd41, 32'h4000_0000, 1'b1);
                        else eng_finish(ST_OK);
                    end else begin
                        m_type = m_resp[30] ? CT_SD2B : CT_SD2;
                        eng_finish(ST_OK);
                    end
                end
            end
            PH_RD_GAP: begin
                m_retry = c_busy;
                eng_go(PH_RD_TOKEN, 8'hFF);
            end
            PH_RD_TOKEN: begin
                if (rx == 8'hFE) begin
                    m_bc = '0;
                    eng_go(PH_RD_DATA, 8'hFF);
                end else begin
                    m_retry = m_retry - 16'd1;
                    if (m_retry == 16'd0) eng_finish(ST_RD_FAIL);
                end
            end
            PH_RD_DATA: begin
                m_out.rv = 1'b1;
                m_out.rd = rx;
                m_bc++;
                if (m_bc >= BLOCK) begin
                    m_out.rl = 1'b1;
                    m_bc = '0;
                    eng_go(PH_RD_CRC, 8'hFF);
                end
            end
            PH_RD_CRC: begin
                m_bc++;
                if (m_bc >= 2) eng_finish(ST_OK);
            end
            PH_WR_TOKEN: begin
                m_bc = '0;
                eng_go(PH_WR_DATA, wbuf[0]);
            end
            PH_WR_DATA: begin
                m_bc++;
                if (m_bc >= BLOCK) begin
                    m_bc = '0;
                    eng_go(PH_WR_REL, 8'hFF);
                end else eng_go(PH_WR_DATA, wbuf[m_bc[8:0]]);
            end
            PH_WR_REL: begin
                m_bc++;
                if (m_bc >= 2) eng_go(PH_WR_RESP, 8'hFF);
            end
            PH_WR_RESP: begin
                if ((rx & 8'h05) != 8'h05) eng_finish(ST_WR_FAIL);
                else begin
                    m_retry = c_busy;
                    eng_go(PH_WR_BUSY, 8'hFF);
                end
            end
            PH_WR_BUSY: begin
                if (rx == 8'hFF) eng_finish(ST_OK);
                else begin
                    m_retry = m_retry - 16'd1;
                    if (m_retry == 16'd0) eng_finish(ST_WR_FAIL);
                end
            end
            default: ;
        endcase
    endfunction

    // Result item of one accepted input item.
    function automatic t_res engine_step(logic [2:0] cmd, logic [7:0] rx, logic [31:0] addr,
                                         logic [8:0] li, logic [7:0] lb);
        m_out = '0;
        if (cmd == CMD_XCHG) begin
            if (m_ph != PH_IDLE) eng_exchange(rx);
        end else if (cmd == CMD_LOAD) begin
            wbuf[li] = lb;
        end else if (m_ph == PH_IDLE) begin
            if (cmd == CMD_INIT) begin
                m_type = CT_NONE;
                m_slow = 1'b1;
                m_cs = 1'b0;
                m_bc = '0;
                eng_go(PH_WAKE, 8'hFF);
            end else if (cmd == CMD_READ) begin
                m_cs = 1'b1;
                eng_send(SG_READ, 6'd17, addr, 1'b0);
            end else if (cmd == CMD_WRITE) begin
                m_cs = 1'b1;
                eng_send(SG_WRITE, 6'd24, addr, 1'b0);
            end
        end
        m_out.txv = (m_ph != PH_IDLE);
        m_out.tx = m_out.txv ? m_tx : 8'h00;
        m_out.cs = m_cs;
        m_out.slow = m_slow;
        m_out.ct = m_type;
        return m_out;
    endfunction

    // Card answer for the next exchange, chosen from the engine's progress.
    function automatic logic [7:0] card_reply();
        int p;
        logic [7:0] b;
        p = $urandom_range(0, 99);
        b = 8'($urandom_range(0, 255));
        case (m_ph)
            PH_R1: begin
                if (p < 12) b = 8'hFF;
                else if (p < 16) b = b;
                else if (m_app) b = (p < 85) ? 8'h01 : 8'h05;
                else begin
                    case (m_sg)
                        SG_GO_IDLE: b = 8'h01;
                        SG_IF_COND, SG_V1_PROBE: b = (p < 58) ? 8'h01 : 8'h05;
                        SG_V2_WAIT, SG_V1_WAIT: b = (p < 50) ? 8'h00 : 8'h01;
                        default: b = (p < 95) ? 8'h00 : 8'h01;
                    endcase
                end
            end
            PH_OCR: begin
                if (p < 90) begin
                    if (m_sg == SG_IF_COND_OCR)
                        b = (m_bc == 2) ? 8'h01 : (m_bc == 3) ? 8'hAA : 8'h00;
                    else if (m_bc == 0) b = (p < 45) ? 8'hC0 : 8'h80;
                end
            end
            PH_RD_TOKEN: b = (p < 25) ? 8'hFE : (p < 97) ? 8'hFF : b;
            PH_RD_DATA: ;
            PH_WR_RESP: if (p < 85) b = 8'hE5;
            PH_WR_BUSY: b = (p < 25) ? 8'hFF : (p < 95) ? 8'h00 : b;
            default: if (p < 50) b = 8'hFF;
        endcase
        return b;
    endfunction

    // Present one item after a gap and record what it should produce.
    task automatic send_item(logic [2:0] cmd, logic [7:0] rx, logic [31:0] addr,
                             logic [8:0] li, logic [7:0] lb, int gap, bit chk, t_res want);
        t_res r;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_rx_byte <= rx;
        i_block_address <= addr;
        i_load_index <= li;
        i_load_byte <= lb;
        do @(posedge i_clk); while (o_stall);
        r = engine_step(cmd, rx, addr, li, lb);
        engine_outputs_q.push_back(chk ? want : r);
    endtask

    // One register write; the caller drops the valid after the last one.
    task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_R1:  c_r1 = data[7:0];
            CFG_V2:  c_v2 = data;
            CFG_V1:  c_v1 = data;
            default: c_busy = data;
        endcase
    endtask

    function automatic t_row mk_row(logic [2:0] cmd, logic [7:0] rx, logic [31:0] addr,
                                    logic [8:0] li, logic [7:0] lb, bit chk, t_res want);
        t_row t;
        t.cmd = cmd; t.rx = rx; t.addr = addr; t.li = li; t.lb = lb;
        t.chk = chk; t.want = want;
        return t;
    endfunction

    function automatic t_res mk_res(logic txv, logic [7:0] tx, logic cs, logic slow,
                                    logic done, logic [1:0] st);
        t_res r;
        r = '0;
        r.txv = txv; r.tx = tx; r.cs = cs; r.slow = slow; r.done = done; r.st = st;
        return r;
    endfunction

    // Result checking and random receiver stall.
    always @(posedge i_clk) begin
        t_res got, want;
        int n;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_tx_valid, o_tx_byte, o_chip_select, o_slow_clock, o_read_valid,
                       o_read_data, o_read_last, o_done_res, o_status, o_card_type};
                if (engine_outputs_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected result item %h", got);
                end else begin
                    want = engine_outputs_q.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch (txv,tx,cs,slow,rv,rd,rl,done,st,type): %s %h %s %h",
                                     "expected", want, "got", got);
                    end
                end
                if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
                n = calm_rx ? 0 : $urandom_range(0, 17);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    stall_left <= n;
                end
            end else if (i_stall) begin
                if (stall_left <= 1) i_stall <= 1'b0;
                else stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog on cycles with no accepted item on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            wd_cnt <= 0;
        else
            wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WD_LIMIT) begin
            $display("[sd_card_spi_host_engine] ERROR");
            $finish;
        end
    end

    initial begin
        t_row dir_tab [$];
        t_res none;
        logic [2:0] cmd;
        logic [7:0] rx;
        int p, n, gap;
        bit calm_tx, ignored;
        logic [15:0] cfg_sets [5][4];

        none = '0;
        cfg_sets = '{'{16'd10, 16'd12000, 16'd25000, 16'hFFFF},
                     '{16'd1, 16'd1, 16'd1, 16'd1},
                     '{16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                     '{16'd2, 16'd3, 16'd2, 16'd4},
                     '{16'd128, 16'd5, 16'd5, 16'h8000}};

        // Directed part: idle exchange, buffer edges, a read with a bad R1,
        // ignored starts while busy, then the opening of an initialisation.
        dir_tab.push_back(mk_row(CMD_XCHG, 8'h00, 32'd0, 9'd0, 8'h00, 1, none));
        dir_tab.push_back(mk_row(CMD_LOAD, 8'h00, 32'd0, 9'd0, 8'hFF, 1, none));
        dir_tab.push_back(mk_row(CMD_LOAD, 8'h00, 32'd0, 9'd511, 8'h00, 1, none));
        dir_tab.push_back(mk_row(CMD_READ, 8'h00, 32'hFFFF_FFFF, 9'd0, 8'h00, 1,
                                 mk_res(1, 8'hFF, 1, 0, 0, ST_OK)));
        dir_tab.push_back(mk_row(CMD_INIT, 8'h00, 32'd0, 9'd0, 8'h00, 0, none));
        dir_tab.push_back(mk_row(CMD_WRITE, 8'h00, 32'd0, 9'd0, 8'h00, 0, none));
        repeat (8) dir_tab.push_back(mk_row(CMD_XCHG, 8'hFF, 32'd0, 9'd0, 8'h00, 0, none));
        dir_tab.push_back(mk_row(CMD_XCHG, 8'h80, 32'd0, 9'd0, 8'h00, 0, none));
        dir_tab.push_back(mk_row(CMD_XCHG, 8'h05, 32'd0, 9'd0, 8'h00, 1,
                                 mk_res(0, 8'h00, 1, 0, 1, ST_RD_FAIL)));
        dir_tab.push_back(mk_row(CMD_INIT, 8'h00, 32'd0, 9'd0, 8'h00, 1,
                                 mk_res(1, 8'hFF, 0, 1, 0, ST_OK)));
        dir_tab.push_back(mk_row(CMD_XCHG, 8'h7F, 32'd0, 9'd0, 8'h00, 0, none));
        dir_tab.push_back(mk_row(CMD_XCHG, 8'h00, 32'd0, 9'd0, 8'h00, 0, none));
        dir_tab.push_back(mk_row(CMD_XCHG, 8'hFF, 32'd0, 9'd0, 8'h00, 0, none));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            send_item(dir_tab[k].cmd, dir_tab[k].rx, dir_tab[k].addr, dir_tab[k].li,
                      dir_tab[k].lb, $urandom_range(0, 17), dir_tab[k].chk, dir_tab[k].want);

        // Whole buffer loaded before any write block goes out.
        for (int k = 0; k < BLOCK; k++)
            send_item(CMD_LOAD, 8'($urandom), $urandom, 9'(k), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0, 0, none);

        calm_tx = 1'b0;
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                i_valid <= 1'b0;
                while (engine_outputs_q.size() != 0) @(posedge i_clk);
                repeat (3) @(posedge i_clk);
                for (int r = 0; r < 4; r++) cfg_write(2'(r), cfg_sets[ph][r]);
                i_cfg_valid <= 1'b0;
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                cmd = CMD_XCHG;
                rx = card_reply();
                p = $urandom_range(0, 99);
                if (m_ph == PH_IDLE) begin
                    if (p < 35) cmd = CMD_INIT;
                    else if (p < 65) cmd = CMD_READ;
                    else if (p < 90) cmd = CMD_WRITE;
                    else if (p >= 95) cmd = CMD_LOAD;
                end else if (p < 2) begin
                    cmd = 3'($urandom_range(CMD_INIT, CMD_WRITE));
                end else if (p < 4) begin
                    cmd = CMD_LOAD;
                end
                ignored = (cmd == CMD_LOAD) || ((m_ph == PH_IDLE) == (cmd == CMD_XCHG));
                if (!ignored) n++;
                if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
                gap = calm_tx ? 0 : $urandom_range(0, 17);
                send_item(cmd, rx, $urandom, 9'($urandom_range(0, 511)),
                          8'($urandom_range(0, 255)), gap, 0, none);
            end
        end

        i_valid <= 1'b0;
        while (engine_outputs_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[sd_card_spi_host_engine] OK");
        else
            $display("[sd_card_spi_host_engine] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sdh_pkg.sv
hdl/sdh_wbuf.sv
hdl/sd_card_spi_host_engine.sv
hdl/sdh_checker.sv
test/tb_sd_card_spi_host_engine.sv
